/* rtl/sdf_csg_pkg.sv */
`timescale 1ns / 1ps

package sdf_csg_pkg;

	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int RES_W    = 34;
	localparam int BLEND_W  = 19;
	localparam int HH_W     = 37;
	localparam int HQ_W     = 21;
	localparam int REC_W    = 22;
	localparam int HMUL_W   = HQ_W + REC_W;
	localparam int REC_SHIFT = 26;
	localparam int CORR_W   = HMUL_W - REC_SHIFT;
	localparam int ROOT_W   = 32;
	localparam int RAD_W    = 2 * ROOT_W;

	localparam logic [BLEND_W-1:0] BLEND_Q16 = 19'd278528;
	localparam logic [REC_W-1:0]   REC17     = 22'd3947581;
	localparam logic [CORR_W-1:0]  CORR_MAX  = 17'd69632;

	localparam logic [MODE_W-1:0] MODE_UNION   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SMOOTH  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROUND   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DIFF_AB = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DIFF_BA = 3'd4;

	typedef enum logic [1:0] {
		SEL_BASE,
		SEL_CORR,
		SEL_ROOT
	} sel_t;

	typedef struct packed {
		logic signed [RES_W-1:0] base;
		logic [CORR_W-1:0]       corr;
		sel_t                    sel;
	} side_t;

endpackage

/* rtl/sdf_csg_sqrt.sv */
`timescale 1ns / 1ps

module sdf_csg_sqrt (
	input  logic                               clk,
	input  logic [sdf_csg_pkg::ROOT_W-1:0]     adv,
	input  logic [sdf_csg_pkg::RAD_W-1:0]      radicand,
	input  sdf_csg_pkg::side_t                 side_in,
	output logic [sdf_csg_pkg::ROOT_W-1:0]     root,
	output sdf_csg_pkg::side_t                 side_out
);
	import sdf_csg_pkg::*;

	localparam int STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int TRY_W = REM_W + 3;

	logic [RAD_W-1:0]  x_s    [STEPS-1];
	logic [REM_W-1:0]  rem_s  [STEPS];
	logic [ROOT_W-1:0] root_s [STEPS];
	side_t             side_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [RAD_W-1:0]  x_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		side_t             side_g;
		logic [TRY_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign x_in    = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_g  = side_in;
		end else begin : g_next
			assign x_in    = x_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign side_g  = side_s[i-1];
		end

		assign trial = {1'b0, rem_in, x_in[RAD_W-1 -: 2]} - {3'b000, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (adv[i]) begin
				if (!trial[TRY_W-1]) begin
					rem_s[i]  <= trial[REM_W-1:0];
					root_s[i] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= {rem_in[REM_W-3:0], x_in[RAD_W-1 -: 2]};
					root_s[i] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				side_s[i] <= side_g;
			end
		end

		if (i < STEPS - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (adv[i]) begin
					x_s[i] <= {x_in[RAD_W-3:0], 2'b00};
				end
			end
		end
	end

	assign root     = root_s[STEPS-1];
	assign side_out = side_s[STEPS-1];

endmodule

/* rtl/sdf_csg_combine.sv */
`timescale 1ns / 1ps

// Combines two signed Q16.16 distance samples per word under the mode held in the
// configuration register (union, smoothed union, rounded union, two differences;
// other codes pass current_value), saturating to VALUE_BITS bits and returning the
// low 32 bits. One word enters per cycle while in_ready is high and passes four stages
// of difference, clamp, multiply and sum, then 32 stages of square root that settle
// one root bit each, then the output register. A stalled output fills the empty
// stages before input ready drops. Write the mode only while the pipeline is empty.
module sdf_csg_combine #(
	parameter int VALUE_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wen,
	input  logic [sdf_csg_pkg::MODE_W-1:0]          cfg_wdata,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [sdf_csg_pkg::DATA_W-1:0]   current_value,
	input  logic signed [sdf_csg_pkg::DATA_W-1:0]   other_value,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [sdf_csg_pkg::DATA_W-1:0]   combined_value
);
	import sdf_csg_pkg::*;

	localparam int PRE = 4;
	localparam int NST = PRE + ROOT_W + 1;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
	localparam logic signed [RES_W-1:0] BLEND_RES =
		$signed({{(RES_W-BLEND_W){1'b0}}, BLEND_Q16});

	logic [MODE_W-1:0] mode_q;
	logic [NST-1:0]    valid_q;
	logic [NST-1:0]    adv;

	logic signed [DATA_W-1:0] a_s1, b_s1;
	logic [MODE_W-1:0]        mode_s1;
	logic signed [DATA_W:0]   diff_s1;
	logic [DATA_W-1:0]        ux_s1, uy_s1;

	sel_t                    sel_s2;
	logic signed [RES_W-1:0] base_s2;
	logic [BLEND_W-1:0]      h_s2;
	logic [DATA_W-1:0]       ux_s2, uy_s2;

	sel_t                    sel_s3;
	logic signed [RES_W-1:0] base_s3;
	logic [HH_W-1:0]         hh_s3;
	logic [RAD_W-1:0]        ux2_s3, uy2_s3;

	sel_t                    sel_s4;
	logic signed [RES_W-1:0] base_s4;
	logic [RAD_W-1:0]        sq_s4;
	logic [HMUL_W-1:0]       hmul_s4;

	logic signed [DATA_W-1:0] result_q;

	logic signed [DATA_W:0]   diff_c, kma_c, kmb_c;
	logic [DATA_W-1:0]        ux_c, uy_c;
	logic [DATA_W:0]          absd_c;
	logic [BLEND_W-1:0]       h_c;
	logic signed [RES_W-1:0]  a_x, b_x, m_x, na_x, nb_x, base_c;
	sel_t                     sel_c;
	side_t                    side_in, side_out;
	logic [ROOT_W-1:0]        root;
	logic [ROOT_W-1:0]        sub_c;
	logic signed [RES_W:0]    res_c;
	logic signed [63:0]       res64_c, sat_c;

	for (genvar i = 0; i < NST; i++) begin : g_adv
		assign adv[i] = out_ready || !(&valid_q[NST-1:i]);
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UNION;
			valid_q <= '0;
		end else begin
			if (cfg_wen) begin
				mode_q <= cfg_wdata;
			end
			if (adv[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign diff_c = {current_value[DATA_W-1], current_value} - {other_value[DATA_W-1], other_value};
	assign kma_c  = $signed({{(DATA_W+1-BLEND_W){1'b0}}, BLEND_Q16})
		- {current_value[DATA_W-1], current_value};
	assign kmb_c  = $signed({{(DATA_W+1-BLEND_W){1'b0}}, BLEND_Q16})
		- {other_value[DATA_W-1], other_value};
	assign ux_c   = kma_c[DATA_W] ? '0 : kma_c[DATA_W-1:0];
	assign uy_c   = kmb_c[DATA_W] ? '0 : kmb_c[DATA_W-1:0];

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			a_s1    <= current_value;
			b_s1    <= other_value;
			mode_s1 <= mode_q;
			diff_s1 <= diff_c;
			ux_s1   <= ux_c;
			uy_s1   <= uy_c;
		end
	end

	assign absd_c = diff_s1[DATA_W] ? (DATA_W+1)'(-diff_s1) : diff_s1;
	assign h_c    = (absd_c >= {{(DATA_W+1-BLEND_W){1'b0}}, BLEND_Q16}) ? '0
		: BLEND_Q16 - absd_c[BLEND_W-1:0];
	assign a_x    = {{(RES_W-DATA_W){a_s1[DATA_W-1]}}, a_s1};
	assign b_x    = {{(RES_W-DATA_W){b_s1[DATA_W-1]}}, b_s1};
	assign na_x   = -a_x;
	assign nb_x   = -b_x;
	assign m_x    = (a_x < b_x) ? a_x : b_x;

	always_comb begin
		sel_c  = SEL_BASE;
		base_c = a_x;
		case (mode_s1)
			MODE_UNION: begin
				base_c = m_x;
			end
			MODE_SMOOTH: begin
				base_c = m_x;
				sel_c  = SEL_CORR;
			end
			MODE_ROUND: begin
				base_c = (m_x > BLEND_RES) ? m_x : BLEND_RES;
				sel_c  = SEL_ROOT;
			end
			MODE_DIFF_AB: begin
				base_c = (na_x > b_x) ? na_x : b_x;
			end
			MODE_DIFF_BA: begin
				base_c = (nb_x > a_x) ? nb_x : a_x;
			end
			default: begin
				base_c = a_x;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sel_s2  <= sel_c;
			base_s2 <= base_c;
			h_s2    <= h_c;
			ux_s2   <= ux_s1;
			uy_s2   <= uy_s1;
		end
		if (adv[2]) begin
			sel_s3  <= sel_s2;
			base_s3 <= base_s2;
			hh_s3   <= h_s2 * h_s2;
			ux2_s3  <= ux_s2 * ux_s2;
			uy2_s3  <= uy_s2 * uy_s2;
		end
		if (adv[3]) begin
			sel_s4  <= sel_s3;
			base_s4 <= base_s3;
			sq_s4   <= ux2_s3 + uy2_s3;
			hmul_s4 <= hh_s3[HH_W-1 -: HQ_W] * REC17;
		end
	end

	assign side_in = '{base: base_s4, corr: hmul_s4[HMUL_W-1 -: CORR_W], sel: sel_s4};

	sdf_csg_sqrt u_sqrt (
		.clk      (clk),
		.adv      (adv[PRE +: ROOT_W]),
		.radicand (sq_s4),
		.side_in  (side_in),
		.root     (root),
		.side_out (side_out)
	);

	always_comb begin
		case (side_out.sel)
			SEL_CORR: sub_c = {{(ROOT_W-CORR_W){1'b0}}, side_out.corr};
			SEL_ROOT: sub_c = root;
			default:  sub_c = '0;
		endcase
	end

	assign res_c   = {side_out.base[RES_W-1], side_out.base} - $signed({1'b0, {(RES_W-ROOT_W){1'b0}}, sub_c});
	assign res64_c = {{(64-RES_W-1){res_c[RES_W]}}, res_c};
	assign sat_c   = (res64_c > SAT_HI) ? SAT_HI : ((res64_c < SAT_LO) ? SAT_LO : res64_c);

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			result_q <= sat_c[DATA_W-1:0];
		end
	end

	assign combined_value = result_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> ((&valid_q) && !out_ready))
		else $error("input stalled with an empty stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(out_valid && out_ready))
		|=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("accepted word not held in pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && out_valid && out_ready)
		|=> ($countones(valid_q) == $past($countones(valid_q)) - 1))
		else $error("delivered word not removed from pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[PRE-1] |-> (hmul_s4[HMUL_W-1 -: CORR_W] <= CORR_MAX))
		else $error("smooth correction out of range");
`endif

endmodule

/* verif/tb_sdf_csg_combine.sv */
`timescale 1ns / 1ps

module tb_sdf_csg_combine;
	import sdf_csg_pkg::*;

	localparam int VALUE_BITS = 32;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 1500;

	localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] DIST_MIN = 32'sh80000000;
	localparam logic signed [DATA_W-1:0] DIST_MAX = 32'sh7fffffff;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wen;
	logic [MODE_W-1:0]          cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [DATA_W-1:0]   current_value;
	logic signed [DATA_W-1:0]   other_value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [DATA_W-1:0]   combined_value;

	int  cycle_count;
	bit  no_idle;

	class csg_scoreboard;
		logic [MODE_W-1:0]        mode;
		logic signed [DATA_W-1:0] expected_dist[$];
		int                       errors;

		function new();
			mode = MODE_UNION;
			errors = 0;
		endfunction

		static function longint unsigned root64(longint unsigned x);
			longint unsigned root;
			longint unsigned b;
			root = 0;
			b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= root + b) begin
					x -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		function logic signed [DATA_W-1:0] combine_expected(logic signed [DATA_W-1:0] a,
				logic signed [DATA_W-1:0] b);
			longint sa, sb, m, res, d, h, k, top;
			longint unsigned ux, uy, len;
			sa = a;
			sb = b;
			k = longint'(BLEND_Q16);
			m = (sa < sb) ? sa : sb;
			case (mode)
				MODE_UNION: begin
					res = m;
				end
				MODE_SMOOTH: begin
					d = sa - sb;
					if (d < 0)
						d = -d;
					h = k - d;
					if (h < 0)
						h = 0;
					res = m - (h * h) / (4 * k);
				end
				MODE_ROUND: begin
					ux = (k - sa > 0) ? longint'(k - sa) : 0;
					uy = (k - sb > 0) ? longint'(k - sb) : 0;
					len = root64(ux * ux + uy * uy);
					res = ((k > m) ? k : m) - longint'(len);
				end
				MODE_DIFF_AB: begin
					res = (-sa > sb) ? -sa : sb;
				end
				MODE_DIFF_BA: begin
					res = (-sb > sa) ? -sb : sa;
				end
				default: begin
					res = sa;
				end
			endcase
			top = (longint'(1) << (VALUE_BITS - 1)) - 1;
			if (res > top)
				res = top;
			else if (res < -top - 1)
				res = -top - 1;
			return res[DATA_W-1:0];
		endfunction

		function void note_input(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
			expected_dist.push_back(combine_expected(a, b));
		endfunction

		function void check_result(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (expected_dist.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected combined_value %0d (0x%08h)", got, got);
				return;
			end
			want = expected_dist.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: mode %0d combined_value expected %0d (0x%08h) got %0d (0x%08h)",
						mode, want, want, got, got);
			end
		endfunction

		function int pending();
			return expected_dist.size();
		endfunction
	endclass

	csg_scoreboard board;

	sdf_csg_combine #(
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.current_value(current_value),
		.other_value(other_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.combined_value(combined_value)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		current_value = a;
		other_value = b;
		do @(posedge clk); while (!in_ready);
		board.note_input(a, b);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] m);
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		cfg_wen = 1'b1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_wen = 1'b0;
		board.mode = m;
	endtask

	function automatic logic signed [DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return DIST_MIN;
			1: return DIST_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return $signed({13'd0, BLEND_Q16});
			5: return $signed({13'd0, BLEND_Q16}) - 32'sd1;
			default: return $signed({13'd0, BLEND_Q16}) + 32'sd1;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $signed($urandom);
			4, 5, 6, 7: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00060000;
			default: return pick_extreme();
		endcase
	endfunction

	initial begin
		logic signed [DATA_W-1:0] dir_a[3];
		logic signed [DATA_W-1:0] dir_b[3];
		logic [MODE_W-1:0]        all_modes[8];
		logic signed [DATA_W-1:0] a, b;
		int                       sent, run_len;

		board = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = MODE_UNION;
		in_valid = 1'b0;
		current_value = '0;
		other_value = '0;
		out_ready = 1'b0;
		cycle_count = 0;
		no_idle = 1'b0;

		dir_a = '{DIST_MIN, DIST_MIN, 32'sh00044000};
		dir_b = '{DIST_MAX, DIST_MIN, 32'sh00030000};
		all_modes = '{MODE_UNION, MODE_SMOOTH, MODE_ROUND, MODE_DIFF_AB, MODE_DIFF_BA,
			MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (all_modes[i]) begin
			write_mode(all_modes[i]);
			foreach (dir_a[j])
				send_word(dir_a[j], dir_b[j]);
		end

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			write_mode(3'($urandom_range(0, 7)));
			no_idle = ($urandom_range(0, 3) == 0);
			run_len = $urandom_range(20, 150);
			repeat (run_len) begin
				a = pick_value();
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: b = pick_value();
					10, 11, 12, 13, 14, 15, 16: begin
						b = a + $signed($urandom_range(0, 32'h00088000)) - 32'sh00044000;
					end
					default: b = a;
				endcase
				send_word(a, b);
				sent++;
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		no_idle = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 13);
			repeat (stall) begin
				@(negedge clk);
				out_ready = 1'b0;
			end
			@(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_result(combined_value);
		end
	end

endmodule
